/* sv/i2p_pkg.sv */
// Shared types, constants and helper functions for the infix-to-postfix converter.
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

  // Operator stack geometry
  localparam int StackDepth = 32;
  localparam int CntW       = $clog2(StackDepth + 1);
  localparam int AddrW      = $clog2(StackDepth);

  // Character codes
  localparam logic [7:0] CharOpen  = 8'h28;
  localparam logic [7:0] CharClose = 8'h29;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharNone  = 8'h00;

  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_code_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPER,
    S_PUSH,
    S_CLOSE,
    S_FLUSH,
    S_FIN
  } conv_state_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_expr;
  } i2p_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    status_t    status;
    logic       last_of_run;
  } i2p_out_t;

  // Sequencer to stack
  typedef struct packed {
    logic     push;
    logic     pop;
    op_code_t code;
  } stack_cmd_t;

  // Stack to sequencer
  typedef struct packed {
    logic     empty;
    logic     full;
    op_code_t top;
  } stack_stat_t;

  function automatic logic [1:0] prec_of(op_code_t code);
    logic [1:0] p;
    case (code)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] code_char(op_code_t code);
    logic [7:0] c;
    case (code)
      OP_OPEN: c = CharOpen;
      OP_ADD:  c = CharPlus;
      OP_SUB:  c = CharMinus;
      OP_MUL:  c = CharStar;
      OP_DIV:  c = CharSlash;
      default: c = CharNone;
    endcase
    return c;
  endfunction

  function automatic op_code_t op_of_char(logic [7:0] ch);
    op_code_t c;
    case (ch)
      CharPlus:  c = OP_ADD;
      CharMinus: c = OP_SUB;
      CharStar:  c = OP_MUL;
      CharSlash: c = OP_DIV;
      default:   c = OP_OPEN;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/i2p_stack.sv */
// Operator stack: synchronous memory, fill count and read-during-write forwarding.
`timescale 1ns / 1ps
`default_nettype none

module i2p_stack (
  input  logic                     clk,
  input  logic                     rst,
  input  i2p_pkg::stack_cmd_t      cmd,
  output i2p_pkg::stack_stat_t     stat
);

  logic [i2p_pkg::CntW-1:0]  count;
  logic [i2p_pkg::CntW-1:0]  count_next;
  logic [i2p_pkg::CntW-1:0]  top_index;
  logic [i2p_pkg::AddrW-1:0] rd_addr;
  logic [i2p_pkg::AddrW-1:0] wr_addr;
  logic                      full;
  logic                      empty;
  logic                      wr_en;
  i2p_pkg::op_code_t         mem [i2p_pkg::StackDepth];
  i2p_pkg::op_code_t         ram_q;
  i2p_pkg::op_code_t         fwd_code;
  logic                      fwd;

  assign full  = (count == i2p_pkg::CntW'(i2p_pkg::StackDepth));
  assign empty = (count == '0);
  assign wr_en = cmd.push && !full;

  // Advance the fill count
  always_comb begin
    count_next = count;
    if (wr_en) begin
      count_next = count + 1'b1;
    end else if (cmd.pop && !empty) begin
      count_next = count - 1'b1;
    end
  end

  // Always read the entry that will be on top next cycle
  assign top_index = count_next - 1'b1;
  assign rd_addr   = top_index[i2p_pkg::AddrW-1:0];
  assign wr_addr   = count[i2p_pkg::AddrW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      fwd   <= 1'b0;
    end else begin
      count <= count_next;
      fwd   <= wr_en && (wr_addr == rd_addr);
    end
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.code;
    end
    ram_q    <= mem[rd_addr];
    fwd_code <= cmd.code;
  end

  // Forward a just-pushed code over the stale read
  assign stat.top   = fwd ? fwd_code : ram_q;
  assign stat.empty = empty;
  assign stat.full  = full;

`ifndef SYNTHESIS
  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop))
    else $error("stack push and pop in the same cycle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !empty)
    else $error("pop from empty stack");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= i2p_pkg::CntW'(i2p_pkg::StackDepth))
    else $error("stack count beyond depth");

  a_push_top: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (stat.top == $past(cmd.code)))
    else $error("pushed code not on top next cycle");
`endif

endmodule

`default_nettype wire

/* sv/infix_to_postfix_converter_core.sv */
// Top level: shunting-yard infix-to-postfix converter with an operator stack in memory.
//
//   Channel   Signals                          Direction  Payload
//   in        in_valid / in_ready / in_data    input      char_in, end_of_expr
//   out       out_valid / out_ready / out_data output     char_out, status, last_of_run
//
// A plain character is accepted and finished; '(' is also pushed; an operator first pops
// each entry of equal or higher precedence, then is pushed; ')' pops entries up to and
// including the '(', or flags underflow on an empty stack. A flush pops every entry. The
// registered stack read port lets the sequencer pop one entry per cycle unless the output
// stalls; the next top is read while the current one is used. Reset empties the stack at
// once; no clearing pass is needed. A stall holds the sequencer only if a result is pending.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2p_pkg::i2p_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output i2p_pkg::i2p_out_t  out_data
);

  i2p_pkg::conv_state_t state;
  i2p_pkg::conv_state_t state_next;
  i2p_pkg::stack_cmd_t  cmd;
  i2p_pkg::stack_stat_t stat;
  i2p_pkg::op_code_t    op_code;
  i2p_pkg::i2p_out_t    pend;
  logic                 pend_valid;
  logic                 last_flag;
  logic                 accept;
  logic                 out_free;
  logic                 can_emit;
  logic                 emit;
  logic [7:0]           emit_char;
  i2p_pkg::status_t     emit_status;
  logic                 finish;
  logic                 pop_ok;
  logic                 move_out;

  i2p_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  assign in_ready = (state == i2p_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign can_emit = !pend_valid || out_free;
  assign pop_ok   = !stat.empty &&
                    (i2p_pkg::prec_of(op_code) <= i2p_pkg::prec_of(stat.top));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      i2p_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_data.char_in)
            i2p_pkg::CharPlus, i2p_pkg::CharMinus,
            i2p_pkg::CharStar, i2p_pkg::CharSlash: state_next = i2p_pkg::S_OPER;
            i2p_pkg::CharOpen:                     state_next = i2p_pkg::S_PUSH;
            i2p_pkg::CharClose:                    state_next = i2p_pkg::S_CLOSE;
            default: state_next = in_data.end_of_expr ? i2p_pkg::S_FLUSH : i2p_pkg::S_FIN;
          endcase
        end
      end
      i2p_pkg::S_OPER: begin
        if (!pop_ok) begin
          state_next = i2p_pkg::S_PUSH;
        end
      end
      i2p_pkg::S_PUSH: begin
        if (!stat.full || can_emit) begin
          state_next = last_flag ? i2p_pkg::S_FLUSH : i2p_pkg::S_FIN;
        end
      end
      i2p_pkg::S_CLOSE: begin
        if ((stat.empty && can_emit) || (!stat.empty && stat.top == i2p_pkg::OP_OPEN)) begin
          state_next = last_flag ? i2p_pkg::S_FLUSH : i2p_pkg::S_FIN;
        end
      end
      i2p_pkg::S_FLUSH: begin
        if (stat.empty) begin
          state_next = i2p_pkg::S_FIN;
        end
      end
      i2p_pkg::S_FIN: begin
        if (!pend_valid || out_free) begin
          state_next = i2p_pkg::S_IDLE;
        end
      end
      default: state_next = i2p_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: results and stack commands
  always_comb begin
    emit        = 1'b0;
    emit_char   = i2p_pkg::CharNone;
    emit_status = i2p_pkg::ST_OK;
    finish      = 1'b0;
    cmd.push    = 1'b0;
    cmd.pop     = 1'b0;
    cmd.code    = op_code;
    case (state)
      i2p_pkg::S_IDLE: begin
        if (accept) begin
          case (in_data.char_in)
            i2p_pkg::CharPlus, i2p_pkg::CharMinus, i2p_pkg::CharStar,
            i2p_pkg::CharSlash, i2p_pkg::CharOpen, i2p_pkg::CharClose: begin
            end
            default: begin
              emit      = 1'b1;
              emit_char = in_data.char_in;
            end
          endcase
        end
      end
      i2p_pkg::S_OPER: begin
        if (pop_ok && can_emit) begin
          emit      = 1'b1;
          emit_char = i2p_pkg::code_char(stat.top);
          cmd.pop   = 1'b1;
        end
      end
      i2p_pkg::S_PUSH: begin
        if (!stat.full) begin
          cmd.push = 1'b1;
        end else if (can_emit) begin
          emit        = 1'b1;
          emit_status = i2p_pkg::ST_OVERFLOW;
        end
      end
      i2p_pkg::S_CLOSE: begin
        if (stat.empty) begin
          if (can_emit) begin
            emit        = 1'b1;
            emit_status = i2p_pkg::ST_UNDERFLOW;
          end
        end else if (stat.top == i2p_pkg::OP_OPEN) begin
          cmd.pop = 1'b1;
        end else if (can_emit) begin
          emit      = 1'b1;
          emit_char = i2p_pkg::code_char(stat.top);
          cmd.pop   = 1'b1;
        end
      end
      i2p_pkg::S_FLUSH: begin
        if (!stat.empty && can_emit) begin
          emit      = 1'b1;
          emit_char = i2p_pkg::code_char(stat.top);
          cmd.pop   = 1'b1;
        end
      end
      i2p_pkg::S_FIN: begin
        finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign move_out = pend_valid && (emit || (finish && out_free));

  // Advance state; hold one result back so the last one can be marked
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= i2p_pkg::S_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        pend_valid <= 1'b1;
      end else if (finish && out_free) begin
        pend_valid <= 1'b0;
      end
      if (move_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_code   <= i2p_pkg::op_of_char(in_data.char_in);
      last_flag <= in_data.end_of_expr;
    end
    if (emit) begin
      pend.char_out    <= emit_char;
      pend.status      <= emit_status;
      pend.last_of_run <= 1'b0;
    end
    if (move_out) begin
      out_data.char_out    <= pend.char_out;
      out_data.status      <= pend.status;
      out_data.last_of_run <= finish;
    end
  end

`ifndef SYNTHESIS
  a_idle_empty_pend: assert property (@(posedge clk) disable iff (rst)
    (state == i2p_pkg::S_IDLE) |-> !pend_valid)
    else $error("held result left over in idle");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (emit && pend_valid) |-> out_free)
    else $error("result overwritten in output register");

  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    (state == i2p_pkg::S_FIN && !pend_valid) |=> (state == i2p_pkg::S_IDLE))
    else $error("sequencer stuck after finishing an item");
`endif

endmodule

`default_nettype wire
